[src/wpc_pkg.sv]
package wpc_pkg;

  localparam int unsigned SUM_W   = 64;
  localparam int unsigned WSUM_W  = 32;
  localparam int unsigned CNT_W   = 17;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned FIELD_W = 32;

  localparam int unsigned IN_DATA_W  = 112;
  localparam int unsigned OUT_DATA_W = 120;

  localparam int unsigned DIV_STEPS  = SUM_W;
  localparam int unsigned STEP_W     = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef struct packed {
    logic  cap_in;
    logic  do_mul;
    logic  do_acc;
    logic  div_load;
    logic  div_step;
    logic  div_store;
    logic  out_load;
    axis_t axis;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } status_t;

endpackage

[src/wpc_div.sv]
module wpc_div (
  input  logic                                clk,
  input  logic                                load,
  input  logic                                step,
  input  logic [wpc_pkg::SUM_W-1:0]           dividend,
  input  logic [wpc_pkg::WSUM_W-1:0]          divisor,
  output logic [wpc_pkg::OUT_W-1:0]           quotient
);

  localparam int unsigned SW = wpc_pkg::SUM_W;
  localparam int unsigned DW = wpc_pkg::WSUM_W;

  logic          neg_r;
  logic [SW-1:0] mag_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dvs_r;

  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          fits;

  assign shifted = {rem_r, mag_r[SW-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = (shifted >= {1'b0, dvs_r});

  // magnitude register shifts out dividend bits and collects quotient bits
  always_ff @(posedge clk) begin
    if (load) begin
      neg_r <= dividend[SW-1];
      mag_r <= dividend[SW-1] ? (~dividend + SW'(1)) : dividend;
      rem_r <= '0;
      dvs_r <= (divisor == '0) ? DW'(1) : divisor;
    end else if (step) begin
      mag_r <= {mag_r[SW-2:0], fits};
      rem_r <= fits ? diff[DW-1:0] : shifted[DW-1:0];
    end
  end

  assign quotient = neg_r ? (~mag_r[wpc_pkg::OUT_W-1:0] + wpc_pkg::OUT_W'(1))
                          : mag_r[wpc_pkg::OUT_W-1:0];

endmodule

[src/wpc_dp.sv]
module wpc_dp #(
  parameter int unsigned MAX_POINTS  = 65536,
  parameter int unsigned COORD_BITS  = 32,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  wpc_pkg::cmd_t                      cmd,
  output wpc_pkg::status_t                   status,
  input  logic                               cfg_we,
  input  logic                               cfg_wdata,
  input  logic [wpc_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [wpc_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tuser
);

  localparam int unsigned SW     = wpc_pkg::SUM_W;
  localparam int unsigned FW     = wpc_pkg::FIELD_W;
  localparam int unsigned OW     = wpc_pkg::OUT_W;
  localparam int unsigned CW     = wpc_pkg::CNT_W;
  localparam int unsigned WSW    = wpc_pkg::WSUM_W;
  localparam int unsigned PROD_W = COORD_BITS + WEIGHT_BITS + 1;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_POINTS);

  logic                          mode_r;
  logic signed [COORD_BITS-1:0]  x_r, y_r, z_r;
  logic [WEIGHT_BITS-1:0]        w_r;
  logic                          last_r;
  logic signed [PROD_W-1:0]      px_r, py_r, pz_r;
  logic [SW-1:0]                 xs_r, ys_r, zs_r;
  logic [WSW-1:0]                ws_r;
  logic [CW-1:0]                 cnt_r;
  logic                          ovf_r;
  logic [OW-1:0]                 rx_r, ry_r, rz_r;
  logic                          out_valid_r;
  logic [wpc_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                          out_ovf_r;

  logic [SW-1:0]                 div_in;
  logic [OW-1:0]                 div_q;
  logic signed [PROD_W-1:0]      px_nxt, py_nxt, pz_nxt;
  logic signed [PROD_W-1:0]      w_s;

  assign w_s    = $signed({{(PROD_W-WEIGHT_BITS){1'b0}}, w_r});
  assign px_nxt = x_r * w_s;
  assign py_nxt = y_r * w_s;
  assign pz_nxt = z_r * w_s;

  always_comb begin
    case (cmd.axis)
      wpc_pkg::AXIS_X: div_in = xs_r;
      wpc_pkg::AXIS_Y: div_in = ys_r;
      wpc_pkg::AXIS_Z: div_in = zs_r;
      default:         div_in = xs_r;
    endcase
  end

  wpc_div u_div (
    .clk      (clk),
    .load     (cmd.div_load),
    .step     (cmd.div_step),
    .dividend (div_in),
    .divisor  (ws_r),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      x_r    <= in_tdata[COORD_BITS-1:0];
      y_r    <= in_tdata[FW+COORD_BITS-1:FW];
      z_r    <= in_tdata[2*FW+COORD_BITS-1:2*FW];
      w_r    <= mode_r ? in_tdata[3*FW+WEIGHT_BITS-1:3*FW] : WEIGHT_BITS'(1);
      last_r <= in_tlast;
    end
    if (cmd.do_mul) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
      pz_r <= pz_nxt;
    end
    if (cmd.div_store) begin
      case (cmd.axis)
        wpc_pkg::AXIS_X: rx_r <= div_q;
        wpc_pkg::AXIS_Y: ry_r <= div_q;
        default:         rz_r <= div_q;
      endcase
    end
    if (cmd.out_load) begin
      out_data_r <= {(wpc_pkg::OUT_DATA_W-3*OW-CW)'(0), cnt_r, rz_r, ry_r, rx_r};
      out_ovf_r  <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b1;
      xs_r        <= '0;
      ys_r        <= '0;
      zs_r        <= '0;
      ws_r        <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (cmd.out_load) begin
        // result captured: start a fresh set
        xs_r        <= '0;
        ys_r        <= '0;
        zs_r        <= '0;
        ws_r        <= '0;
        cnt_r       <= '0;
        ovf_r       <= 1'b0;
        out_valid_r <= 1'b1;
      end else begin
        if (cmd.do_acc) begin
          if (cnt_r < CNT_MAX) begin
            xs_r  <= xs_r + {{(SW-PROD_W){px_r[PROD_W-1]}}, px_r};
            ys_r  <= ys_r + {{(SW-PROD_W){py_r[PROD_W-1]}}, py_r};
            zs_r  <= zs_r + {{(SW-PROD_W){pz_r[PROD_W-1]}}, pz_r};
            ws_r  <= ws_r + {{(WSW-WEIGHT_BITS){1'b0}}, w_r};
            cnt_r <= cnt_r + CW'(1);
          end else begin
            ovf_r <= 1'b1;
          end
        end
        if (out_tready) begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  assign status.last     = last_r;
  assign status.out_busy = out_valid_r & ~out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ovf_r;

endmodule

[src/wpc_ctrl.sv]
module wpc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  wpc_pkg::status_t  status,
  output wpc_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_DLOAD,
    S_DSTEP,
    S_DSTORE,
    S_OUT
  } state_t;

  localparam int unsigned SW = wpc_pkg::STEP_W;
  localparam logic [SW-1:0] STEP_LAST = SW'(wpc_pkg::DIV_STEPS - 1);

  state_t          state_r, state_nxt;
  wpc_pkg::axis_t  axis_r, axis_nxt;
  logic [SW-1:0]   step_r, step_nxt;

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    step_nxt      = step_r;
    cmd           = '0;
    cmd.axis      = axis_r;
    in_tready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.cap_in = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.do_mul = 1'b1;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        cmd.do_acc = 1'b1;
        axis_nxt   = wpc_pkg::AXIS_X;
        state_nxt  = status.last ? S_DLOAD : S_IDLE;
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + SW'(1);
        if (step_r == STEP_LAST) begin
          state_nxt = S_DSTORE;
        end
      end
      S_DSTORE: begin
        cmd.div_store = 1'b1;
        case (axis_r)
          wpc_pkg::AXIS_X: begin
            axis_nxt  = wpc_pkg::AXIS_Y;
            state_nxt = S_DLOAD;
          end
          wpc_pkg::AXIS_Y: begin
            axis_nxt  = wpc_pkg::AXIS_Z;
            state_nxt = S_DLOAD;
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_OUT: begin
        // hold until the output register is free
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= wpc_pkg::AXIS_X;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

[src/weighted_point_centroid.sv]
// Channel  Dir  Beat contents (tdata from bit 0 up)
// in_      in   x_coord[31:0], y_coord[63:32], z_coord[95:64], weight[111:96]; tlast last_point
// out_     out  x_center[31:0], y_center[63:32], z_center[95:64], points_used[112:96];
//               tuser count_overflow
// cfg_     in   weighted_mode on cfg_wdata when cfg_we is high
//
// A point that does not close a set passes through capture, multiply, accumulate.
// A closing point then runs load, step and store for each axis: one shared radix-2 divider
// produces one quotient bit per cycle for x, y and z in turn.
// rst_n clears the sums, counters and output valid and sets weighted_mode to 1.
// The result sits in an output register; the next point is taken while it waits,
// and only the load of a following result stalls on a full output register.
module weighted_point_centroid #(
  parameter int unsigned MAX_POINTS  = 65536,
  parameter int unsigned COORD_BITS  = 32,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // x_coord, y_coord, z_coord, weight
  input  logic [wpc_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // x_center, y_center, z_center, points_used, zero fill
  output logic [wpc_pkg::OUT_DATA_W-1:0]    out_tdata,
  // count_overflow
  output logic                              out_tuser
);

  wpc_pkg::cmd_t    cmd;
  wpc_pkg::status_t status;

  wpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  wpc_dp #(
    .MAX_POINTS  (MAX_POINTS),
    .COORD_BITS  (COORD_BITS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
